FILE: rtl/hlr_pkg.sv
// hlr_pkg: shared widths and constants for the largest rectangle unit
// no dependencies; imported by histogram_largest_rectangle_unit and its test
package hlr_pkg;

  localparam int HEIGHT_W   = 16;
  localparam int AREA_W     = 26;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [AREA_W-1:0]   area_t;

endpackage

FILE: rtl/histogram_largest_rectangle_unit.sv
// histogram_largest_rectangle_unit: largest rectangle over a stream of bar heights
// monotonic stack kept in one synchronous ram, top entry cached in flops
// depends on hlr_pkg
//
//  channel | dir | signals                             | contents
//  --------+-----+-------------------------------------+------------------------------
//  s_axis  | in  | tvalid tready tdata[15:0] tlast     | bar height, last bar of frame
//  m_axis  | out | tvalid tready tdata[31:0] tuser[0]  | max area, too many bars
//
// a bar is accepted, then compared and pushed; every stack entry it pops is scored
// first, and a pop other than the bottom entry waits on the ram read below the top.
// the last bar then pops and scores each remaining entry the same way and finishes
// once the last product is in the max, later while the output register is still full.
// rst is synchronous and clears the stack depth, position and running max.
// a result waits in the output register; a new frame may be taken meanwhile,
// and the next result is held back only while that register is still full.
module histogram_largest_rectangle_unit #(
  parameter int MAX_BARS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] height
  input  logic [hlr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [25:0] max_area, [31:26] zero
  output logic [hlr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] too_many_bars
  output logic [hlr_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import hlr_pkg::*;

  localparam int PW     = $clog2(MAX_BARS + 1);
  localparam int IW     = $clog2(MAX_BARS);
  localparam int PROD_W = HEIGHT_W + PW;
  localparam int ENT_W  = HEIGHT_W + IW;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_BARS);

  localparam logic [2:0] S_IN    = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FLOAD = 3'd4;

  logic [2:0]        state, state_next;
  logic [PW-1:0]     depth, depth_next;
  logic [PW-1:0]     pos, pos_next;
  area_t             best, best_next;
  logic              ovf, ovf_next;
  height_t           cur_h, cur_h_next;
  logic              cur_last, cur_last_next;
  logic [IW-1:0]     start, start_next;
  height_t           top_h, top_h_next;
  logic [IW-1:0]     top_s, top_s_next;
  logic [PROD_W-1:0] prod;
  logic              prod_valid, prod_valid_next;
  logic              out_valid, out_valid_next;
  area_t             out_area;
  logic              out_ovf;
  logic              out_load;

  // stack ram, entries below the cached top
  logic [ENT_W-1:0] stack_mem [MAX_BARS];
  logic [ENT_W-1:0] rd_data;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic             wr_en;

  logic             in_req;
  logic             do_pop;
  logic             do_score;
  logic [PW-1:0]    width;
  logic [PROD_W-1:0] prod_next;
  area_t            prod_sat;

  assign in_req = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IN);
  assign do_pop = (depth != '0) && (top_h >= cur_h);

  // score of the cached top against the current position
  assign width     = pos - PW'(top_s);
  assign prod_next = PROD_W'(top_h) * PROD_W'(width);
  assign prod_sat  = (prod > PROD_W'(AREA_MAX)) ? AREA_MAX : prod[AREA_W-1:0];

  assign rd_addr = IW'(depth - PW'(2));
  assign wr_addr = IW'(depth - PW'(1));

  always_comb begin
    state_next      = state;
    depth_next      = depth;
    pos_next        = pos;
    best_next       = best;
    ovf_next        = ovf;
    cur_h_next      = cur_h;
    cur_last_next   = cur_last;
    start_next      = start;
    top_h_next      = top_h;
    top_s_next      = top_s;
    out_valid_next  = out_valid;
    out_load        = 1'b0;
    wr_en           = 1'b0;
    do_score        = 1'b0;

    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    // running max from the registered product
    if (prod_valid && (prod_sat > best)) begin
      best_next = prod_sat;
    end

    case (state)
      S_IN: begin
        if (in_req) begin
          cur_h_next    = s_axis_tdata[HEIGHT_W-1:0];
          cur_last_next = s_axis_tlast;
          if (pos >= MAX_POS) begin
            ovf_next = 1'b1;
            if (s_axis_tlast) begin
              state_next = S_FLUSH;
            end
          end else begin
            start_next = pos[IW-1:0];
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (do_pop) begin
          do_score   = 1'b1;
          start_next = top_s;
          depth_next = depth - PW'(1);
          state_next = (depth > PW'(1)) ? S_LOAD : S_CMP;
        end else begin
          // push: old top spills to ram, new bar becomes top
          wr_en      = (depth != '0);
          top_h_next = cur_h;
          top_s_next = start;
          depth_next = depth + PW'(1);
          pos_next   = pos + PW'(1);
          state_next = cur_last ? S_FLUSH : S_IN;
        end
      end
      S_LOAD: begin
        top_h_next = rd_data[ENT_W-1:IW];
        top_s_next = rd_data[IW-1:0];
        state_next = S_CMP;
      end
      S_FLUSH: begin
        if (depth != '0) begin
          do_score   = 1'b1;
          depth_next = depth - PW'(1);
          state_next = (depth > PW'(1)) ? S_FLOAD : S_FLUSH;
        end else if (!prod_valid && (!out_valid || m_axis_tready)) begin
          // best is final, hand it off and clear for the next frame
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          depth_next     = '0;
          pos_next       = '0;
          best_next      = '0;
          ovf_next       = 1'b0;
          state_next     = S_IN;
        end
      end
      S_FLOAD: begin
        top_h_next = rd_data[ENT_W-1:IW];
        top_s_next = rd_data[IW-1:0];
        state_next = S_FLUSH;
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  assign prod_valid_next = do_score;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IN;
      depth      <= '0;
      pos        <= '0;
      best       <= '0;
      ovf        <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      depth      <= depth_next;
      pos        <= pos_next;
      best       <= best_next;
      ovf        <= ovf_next;
      prod_valid <= prod_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_h    <= cur_h_next;
    cur_last <= cur_last_next;
    start    <= start_next;
    top_h    <= top_h_next;
    top_s    <= top_s_next;
    prod     <= prod_next;
    if (out_load) begin
      out_area <= best;
      out_ovf  <= ovf;
    end
  end

  // stack ram ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= {top_h, top_s};
    end
    rd_data <= stack_mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-AREA_W){1'b0}}, out_area};
  assign m_axis_tuser  = out_ovf;

  // checks
  a_depth_le_pos: assert property (@(posedge clk) disable iff (rst)
    depth <= pos)
    else $error("stack deeper than bar count");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    (in_req && (pos < MAX_POS)) |=> (state == S_CMP))
    else $error("accepted bar did not go to compare");

  a_prod_after_score: assert property (@(posedge clk) disable iff (rst)
    prod_valid |-> $past(state == S_CMP || state == S_FLUSH))
    else $error("product valid without a score cycle");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (depth == '0) && (pos == '0) && (best == '0) && m_axis_tvalid)
    else $error("state not cleared after result");

endmodule

FILE: bench/histogram_largest_rectangle_unit_test.sv
// histogram_largest_rectangle_unit_test: stream test of the largest rectangle unit
// drives bar frames, predicts each frame's area and bar-limit flag, checks every result
// depends on hlr_pkg and histogram_largest_rectangle_unit
module histogram_largest_rectangle_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hlr_pkg::*;

  localparam int BAR_LIMIT = 1024;
  localparam int PAD_W     = OUT_DATA_W - AREA_W;

  typedef struct packed {
    area_t area;
    logic  too_many;
  } frame_area_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // expected frame results, oldest first
  frame_area_t pending_areas[$];

  // predicted stack and running state of the current frame
  height_t     bar_stack_h[$];
  int unsigned bar_stack_start[$];
  int unsigned bar_count;
  area_t       best_area_so_far;
  logic        bars_dropped;

  // heights of the frame about to be sent
  height_t frame_bars[$];

  // traffic shaping
  bit          sender_gaps   = 1'b1;
  bit          receiver_gaps = 1'b1;
  int unsigned receiver_hold = 0;

  int unsigned errors        = 0;
  int unsigned bars_sent     = 0;
  int unsigned frames_sent   = 0;
  int unsigned areas_checked = 0;
  int unsigned capped_frames = 0;

  histogram_largest_rectangle_unit #(
    .MAX_BARS(BAR_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #10ms;
    $display("histogram_largest_rectangle_unit_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // score one stack entry spanning [start, stop), saturating at the area width
  function automatic void score_span(input height_t h, input int unsigned start,
                                     input int unsigned stop);
    longint unsigned a;
    a = longint'(h) * longint'(stop - start);
    if (a > longint'(AREA_MAX)) a = longint'(AREA_MAX);
    if (a > longint'(best_area_so_far)) best_area_so_far = area_t'(a);
  endfunction

  // advance the predicted stack by one accepted bar; queue a result on the last bar
  function automatic void track_bar(input height_t h, input logic last);
    int unsigned start;
    if (bar_count >= BAR_LIMIT) begin
      bars_dropped = 1'b1;
    end else begin
      start = bar_count;
      while (bar_stack_h.size() > 0 && bar_stack_h[$] >= h) begin
        score_span(bar_stack_h[$], bar_stack_start[$], bar_count);
        start = bar_stack_start[$];
        void'(bar_stack_h.pop_back());
        void'(bar_stack_start.pop_back());
      end
      bar_stack_h.push_back(h);
      bar_stack_start.push_back(start);
      bar_count++;
    end
    if (last) begin
      while (bar_stack_h.size() > 0) begin
        score_span(bar_stack_h[$], bar_stack_start[$], bar_count);
        void'(bar_stack_h.pop_back());
        void'(bar_stack_start.pop_back());
      end
      pending_areas.push_back('{area: best_area_so_far, too_many: bars_dropped});
      frames_sent++;
      if (bars_dropped) capped_frames++;
      bar_count        = 0;
      best_area_so_far = '0;
      bars_dropped     = 1'b0;
    end
  endfunction

  // offer one bar request and wait for it to be taken; called at a falling edge
  task automatic offer_bar(input height_t h, input logic last);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    track_bar(h, last);
    bars_sent++;
    @(negedge clk);
  endtask

  task automatic offer_frame();
    foreach (frame_bars[i]) offer_bar(frame_bars[i], i == frame_bars.size() - 1);
  endtask

  // stop sending and wait until every queued result has come back
  task automatic wait_for_areas();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_areas.size() != 0);
  endtask

  // mostly short frames, a few longer ones
  function automatic int unsigned pick_frame_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 16);
    if (roll < 95) return $urandom_range(17, 48);
    return $urandom_range(49, 100);
  endfunction

  // random frame content: wide heights, few levels, extremes, or sorted runs
  function automatic void fill_random_frame(input int unsigned len);
    int unsigned style;
    style = $urandom_range(0, 5);
    frame_bars.delete();
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        2: frame_bars.push_back(height_t'($urandom_range(0, 7)));
        3: begin
          case ($urandom_range(0, 2))
            0: frame_bars.push_back(16'h0000);
            1: frame_bars.push_back(16'hFFFF);
            default: frame_bars.push_back(height_t'($urandom_range(65000, 65535)));
          endcase
        end
        default: frame_bars.push_back(height_t'($urandom_range(0, 65535)));
      endcase
    end
    if (style == 4) frame_bars.sort();
    if (style == 5) frame_bars.rsort();
  endfunction

  // result checker
  always @(posedge clk) begin : check_area
    frame_area_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_areas.size() == 0) begin
        report_mismatch($sformatf("result with none expected, tdata=%0h tuser=%0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_areas.pop_front();
        if (m_axis_tdata !== {{PAD_W{1'b0}}, want.area})
          report_mismatch($sformatf("area %0d, expected %0d", m_axis_tdata, want.area));
        if (m_axis_tuser[0] !== want.too_many)
          report_mismatch($sformatf("too_many_bars %0b, expected %0b",
                                    m_axis_tuser[0], want.too_many));
        areas_checked++;
      end
    end
  end

  // receiver: random stall bursts, or a long hold when one is asked for
  initial begin : receiver
    @(negedge clk);
    forever begin
      if (receiver_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (receiver_hold) @(negedge clk);
        receiver_hold = 0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // single bars, extremes, equal runs, monotone runs and a mixed shape
  task automatic test_directed_shapes();
    frame_bars = '{16'd0};
    offer_frame();
    frame_bars = '{16'hFFFF};
    offer_frame();
    frame_bars = '{16'd1, 16'd2, 16'd3, 16'd4};
    offer_frame();
    frame_bars = '{16'd4, 16'd3, 16'd2, 16'd1};
    offer_frame();
    frame_bars = '{16'd7, 16'd7, 16'd7};
    offer_frame();
    frame_bars = '{16'd2, 16'd1, 16'd5, 16'd6, 16'd2, 16'd3};
    offer_frame();
    frame_bars = '{16'd0, 16'hFFFF, 16'd0};
    offer_frame();
    frame_bars = '{16'h8000, 16'h7FFF};
    offer_frame();
    wait_for_areas();
  endtask

  // rising heights fill the stack to the bar limit, then three more bars are
  // dropped and flagged, the last of them carrying the last mark
  task automatic test_bar_limit();
    frame_bars.delete();
    for (int i = 0; i < BAR_LIMIT; i++)
      frame_bars.push_back(height_t'(i * 64 + $urandom_range(0, 63)));
    repeat (3) frame_bars.push_back(height_t'($urandom_range(0, 65535)));
    offer_frame();
    // flag must clear for the next frame
    frame_bars = '{16'd9, 16'd9};
    offer_frame();
    wait_for_areas();
  endtask

  // receiver holds off long enough for the unit to fill and stall its input
  task automatic test_output_stall();
    wait_for_areas();
    receiver_hold = 400;
    repeat (20) begin
      fill_random_frame($urandom_range(1, 4));
      offer_frame();
    end
    wait_for_areas();
  endtask

  // random frames with idling on both sides and occasional full drains
  task automatic test_random_frames(input int unsigned bar_target);
    int unsigned start_bars;
    start_bars = bars_sent;
    while (bars_sent - start_bars < bar_target) begin
      fill_random_frame(pick_frame_len());
      offer_frame();
      if ($urandom_range(0, 14) == 0) wait_for_areas();
    end
    wait_for_areas();
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    repeat (8) begin
      fill_random_frame($urandom_range(1, 16));
      offer_frame();
    end
    wait_for_areas();
  endtask

  initial begin : main
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_shapes();
    test_bar_limit();
    test_output_stall();
    test_random_frames(60);
    test_steady_stream();

    repeat (64) @(negedge clk);
    $display("covered %0d bars in %0d frames, %0d results checked", bars_sent,
             frames_sent, areas_checked);
    $display("%0d frames ran past the %0d-bar limit, one long output stall", capped_frames,
             BAR_LIMIT);
    if (errors == 0 && pending_areas.size() == 0) begin
      $display("histogram_largest_rectangle_unit_test OK");
    end else begin
      $display("histogram_largest_rectangle_unit_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hlr_pkg.sv
rtl/histogram_largest_rectangle_unit.sv
bench/histogram_largest_rectangle_unit_test.sv
